/* design/gac_pkg.sv */
// Shared constants, types and gamma tables for the ARGB color interpolator.
package gac_pkg;

    localparam int unsigned FRACTION_BITS_DEFAULT = 15;
    localparam int unsigned LINEAR_BITS = 16;
    localparam int unsigned CHANNELS = 3;
    localparam int unsigned SEARCH_STAGES = 8;

    typedef logic [LINEAR_BITS-1:0] gac_lin_t;
    typedef gac_lin_t [255:0] gac_table_t;
    typedef logic [255:0] gac_big_t;

    // Item handed from the linear blend stages to the threshold search.
    typedef struct packed {
        logic [7:0]                  alpha;
        gac_lin_t [CHANNELS-1:0]     lin;
    } gac_item_t;

    // extra * x^5 * y^11, exact.
    function automatic gac_big_t gac_term(logic [31:0] extra, logic [31:0] x, logic [31:0] y);
        gac_big_t b;
        b = 256'(extra);
        for (int i = 0; i < 5; i++)
        begin
            b = b * 256'(x);
        end
        for (int i = 0; i < 11; i++)
        begin
            b = b * 256'(y);
        end
        return b;
    endfunction

    // Smallest v in 0..LMAX meeting the rounding or ceiling predicate.
    function automatic logic [31:0] gac_solve(logic [31:0] p, logic [31:0] q, logic round_mode);
        logic [31:0] lmax;
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] mid;
        gac_big_t    rhs;
        gac_big_t    lhs;
        logic        ok;
        lmax = (32'd1 << LINEAR_BITS) - 32'd1;
        lo   = 32'd0;
        hi   = lmax + 32'd1;
        rhs  = gac_term(round_mode ? 32'd32 : 32'd1, lmax, p);
        for (int it = 0; it < 24; it++)
        begin
            if (lo < hi)
            begin
                mid = lo + ((hi - lo) >> 1);
                lhs = gac_term(32'd1, round_mode ? ((mid << 1) + 32'd1) : mid, q);
                ok  = round_mode ? (lhs > rhs) : (lhs >= rhs);
                if (ok)
                begin
                    hi = mid;
                end
                else
                begin
                    lo = mid + 32'd1;
                end
            end
        end
        return (lo > lmax) ? lmax : lo;
    endfunction

    // Gamma-to-linear table, or linear thresholds back to gamma codes.
    function automatic gac_table_t gac_build_table(logic thr_mode);
        gac_table_t  t;
        logic [31:0] k;
        logic [31:0] v;
        for (int hi_n = 0; hi_n < 16; hi_n++)
        begin
            for (int lo_n = 0; lo_n < 16; lo_n++)
            begin
                k = 32'(hi_n * 16 + lo_n);
                if (thr_mode)
                begin
                    v = (k == 32'd0) ? 32'd0 : gac_solve((k << 1) - 32'd1, 32'd510, 1'b0);
                end
                else
                begin
                    v = gac_solve(k, 32'd255, 1'b1);
                end
                t[k[7:0]] = v[LINEAR_BITS-1:0];
            end
        end
        return t;
    endfunction

    localparam gac_table_t LIN_TABLE = gac_build_table(1'b0);
    localparam gac_table_t THR_TABLE = gac_build_table(1'b1);

endpackage

/* design/gamma_argb_color_interpolator.sv */
// Top level of the gamma-corrected ARGB color interpolator.
//
//  channel  | direction | tdata fields (lowest bit first)                     | tuser/tlast
//  s_axis   | in        | blend_fraction[15:0], start_color[47:16],           | none
//           |           | end_color[79:48]                                    |
//  m_axis   | out       | blended_color[31:0]                                 | none
//
// Throughput: one transaction per clock while m_axis_tready is high. Pipeline
// from input to output register: saturate, gamma-to-linear lookup, multiply, sum
// and round, then eight stages of binary search over the 255 linear thresholds.
// Reset clears only the valid bits; payload registers hold whatever they had.
// Stalls: each stage loads when it is empty or its successor moves, so bubbles
// are squeezed out; input is taken while a result waits, until every stage is full.
module gamma_argb_color_interpolator
    import gac_pkg::*;
#(
    parameter int unsigned FRACTION_BITS = FRACTION_BITS_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // blend_fraction[15:0], start_color[47:16], end_color[79:48]
    input  logic [79:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // blended_color[31:0]
    output logic [31:0] m_axis_tdata
);

    localparam int unsigned FW = FRACTION_BITS + 1;        // fraction incl. the one
    localparam int unsigned AW = 8 + FW;                   // alpha product width
    localparam int unsigned LW = LINEAR_BITS + FW;         // linear product width
    localparam logic [16:0]   ONE_WIDE = 17'd1 << FRACTION_BITS;
    localparam logic [FW-1:0] ONE      = {1'b1, {FRACTION_BITS{1'b0}}};
    localparam logic [AW-1:0] HALF_A   = AW'(ONE >> 1);
    localparam logic [LW-1:0] HALF_L   = LW'(ONE >> 1);

    // Input fields.
    logic [15:0] blend_fraction;
    logic [31:0] start_color;
    logic [31:0] end_color;
    logic [16:0] frac_wide;
    logic [16:0] frac_sat;

    // Stage 1: saturated fraction and its complement.
    logic          v1_reg;
    logic [FW-1:0] frac1_reg, frac1_next;
    logic [FW-1:0] comp1_reg, comp1_next;
    logic [31:0]   start1_reg;
    logic [31:0]   end1_reg;

    // Stage 2: linear-light values.
    logic          v2_reg;
    logic [FW-1:0] frac2_reg;
    logic [FW-1:0] comp2_reg;
    logic [7:0]    alpha_s2_reg, alpha_s2_next;
    logic [7:0]    alpha_e2_reg, alpha_e2_next;
    gac_lin_t      lin_s2_reg [CHANNELS];
    gac_lin_t      lin_s2_next[CHANNELS];
    gac_lin_t      lin_e2_reg [CHANNELS];
    gac_lin_t      lin_e2_next[CHANNELS];

    // Stage 3: weighted products.
    logic          v3_reg;
    logic [AW-1:0] alpha_ps3_reg, alpha_ps3_next;
    logic [AW-1:0] alpha_pe3_reg, alpha_pe3_next;
    logic [LW-1:0] lin_ps3_reg [CHANNELS];
    logic [LW-1:0] lin_ps3_next[CHANNELS];
    logic [LW-1:0] lin_pe3_reg [CHANNELS];
    logic [LW-1:0] lin_pe3_next[CHANNELS];

    // Stage 4: rounded blend, handed to the search.
    logic          v4_reg;
    gac_item_t     item4_reg, item4_next;
    logic [AW-1:0] alpha_sum;
    logic [LW-1:0] lin_sum [CHANNELS];

    logic en1, en2, en3, en4;
    logic srch_ready;

    assign blend_fraction = s_axis_tdata[15:0];
    assign start_color    = s_axis_tdata[47:16];
    assign end_color      = s_axis_tdata[79:48];

    // Clamp anything beyond one to exactly one.
    assign frac_wide  = {1'b0, blend_fraction};
    assign frac_sat   = (frac_wide > ONE_WIDE) ? ONE_WIDE : frac_wide;
    assign frac1_next = frac_sat[FW-1:0];
    assign comp1_next = ONE - frac_sat[FW-1:0];

    // Look up linear light for R, G, B; alpha stays as is.
    always_comb
    begin
        alpha_s2_next = start1_reg[31:24];
        alpha_e2_next = end1_reg[31:24];
        for (int c = 0; c < CHANNELS; c++)
        begin
            lin_s2_next[c] = LIN_TABLE[start1_reg[8*c +: 8]];
            lin_e2_next[c] = LIN_TABLE[end1_reg[8*c +: 8]];
        end
    end

    // Weight start by (one - f) and end by f.
    always_comb
    begin
        alpha_ps3_next = AW'(alpha_s2_reg) * AW'(comp2_reg);
        alpha_pe3_next = AW'(alpha_e2_reg) * AW'(frac2_reg);
        for (int c = 0; c < CHANNELS; c++)
        begin
            lin_ps3_next[c] = LW'(lin_s2_reg[c]) * LW'(comp2_reg);
            lin_pe3_next[c] = LW'(lin_e2_reg[c]) * LW'(frac2_reg);
        end
    end

    // Add, round half up, drop the fraction bits.
    always_comb
    begin
        alpha_sum        = alpha_ps3_reg + alpha_pe3_reg + HALF_A;
        item4_next.alpha = alpha_sum[FRACTION_BITS +: 8];
        for (int c = 0; c < CHANNELS; c++)
        begin
            lin_sum[c]       = lin_ps3_reg[c] + lin_pe3_reg[c] + HALF_L;
            item4_next.lin[c] = lin_sum[c][FRACTION_BITS +: LINEAR_BITS];
        end
    end

    // Each stage advances when empty or when its successor advances.
    assign en4 = !v4_reg || srch_ready;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign s_axis_tready = en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= s_axis_tvalid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
            if (en4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            frac1_reg  <= frac1_next;
            comp1_reg  <= comp1_next;
            start1_reg <= start_color;
            end1_reg   <= end_color;
        end
        if (en2)
        begin
            frac2_reg    <= frac1_reg;
            comp2_reg    <= comp1_reg;
            alpha_s2_reg <= alpha_s2_next;
            alpha_e2_reg <= alpha_e2_next;
            for (int c = 0; c < CHANNELS; c++)
            begin
                lin_s2_reg[c] <= lin_s2_next[c];
                lin_e2_reg[c] <= lin_e2_next[c];
            end
        end
        if (en3)
        begin
            alpha_ps3_reg <= alpha_ps3_next;
            alpha_pe3_reg <= alpha_pe3_next;
            for (int c = 0; c < CHANNELS; c++)
            begin
                lin_ps3_reg[c] <= lin_ps3_next[c];
                lin_pe3_reg[c] <= lin_pe3_next[c];
            end
        end
        if (en4)
        begin
            item4_reg <= item4_next;
        end
    end

    // Convert linear light back to gamma codes; last stage is the output register.
    gac_gamma_search u_search (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v4_reg),
        .in_ready  (srch_ready),
        .in_item   (item4_reg),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_color (m_axis_tdata)
    );

endmodule

/* design/gac_gamma_search.sv */
// Pipelined binary search of linear values against the gamma thresholds.
module gac_gamma_search
    import gac_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  gac_item_t   in_item,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] out_color
);

    typedef struct packed {
        logic [7:0]                  alpha;
        gac_lin_t [CHANNELS-1:0]     lin;
        logic [CHANNELS-1:0][7:0]    code;
    } gac_srch_t;

    gac_srch_t                 stage_reg  [SEARCH_STAGES];
    gac_srch_t                 stage_next [SEARCH_STAGES];
    gac_srch_t                 src        [SEARCH_STAGES];
    logic [SEARCH_STAGES-1:0]  vld_reg;
    logic [SEARCH_STAGES-1:0]  vld_next;
    logic [SEARCH_STAGES-1:0]  en;
    logic [7:0]                cand       [SEARCH_STAGES][CHANNELS];

    // Stage k settles bit (7 - k) of each code.
    always_comb
    begin
        for (int k = 0; k < SEARCH_STAGES; k++)
        begin
            if (k == 0)
            begin
                src[k].alpha = in_item.alpha;
                src[k].lin   = in_item.lin;
                src[k].code  = '0;
            end
            else
            begin
                src[k] = stage_reg[k-1];
            end
            stage_next[k] = src[k];
            for (int c = 0; c < CHANNELS; c++)
            begin
                cand[k][c] = src[k].code[c] | (8'd1 << (SEARCH_STAGES - 1 - k));
                if (THR_TABLE[cand[k][c]] <= src[k].lin[c])
                begin
                    stage_next[k].code[c] = cand[k][c];
                end
            end
        end
    end

    // Backpressure: a stage loads when empty or when the next one moves.
    always_comb
    begin
        en[SEARCH_STAGES-1] = !vld_reg[SEARCH_STAGES-1] || out_ready;
        for (int k = SEARCH_STAGES - 2; k >= 0; k--)
        begin
            en[k] = !vld_reg[k] || en[k+1];
        end
        vld_next = vld_reg;
        for (int k = 0; k < SEARCH_STAGES; k++)
        begin
            if (en[k])
            begin
                vld_next[k] = (k == 0) ? in_valid : vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < SEARCH_STAGES; k++)
        begin
            if (en[k])
            begin
                stage_reg[k] <= stage_next[k];
            end
        end
    end

    assign in_ready  = en[0];
    assign out_valid = vld_reg[SEARCH_STAGES-1];
    assign out_color = {stage_reg[SEARCH_STAGES-1].alpha,
                        stage_reg[SEARCH_STAGES-1].code[2],
                        stage_reg[SEARCH_STAGES-1].code[1],
                        stage_reg[SEARCH_STAGES-1].code[0]};

endmodule

/* design/gac_checker.sv */
// Port-level checks for the ARGB color interpolator, bound to the top level.
module gac_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [79:0] s_axis_tdata,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata
);

    // Reset empties the pipeline, so no result shows in the cycle after a reset edge.
    assert property (@(posedge clk) !rst_n |=> !m_axis_tvalid)
        else $error("output valid during or right after reset");

    // Handshake outputs are always driven to known levels out of reset.
    assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown({m_axis_tvalid, s_axis_tready}))
        else $error("unknown handshake output");

    // The block never throttles input by itself when the sink is ready.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("input stalled while output side is ready");

    // A stalled result holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled output transaction changed");

endmodule

bind gamma_argb_color_interpolator gac_checker u_gac_checker (.*);
